### sv/sse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_SORT   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } status_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SORT_RD,
        ST_SORT_LD,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_END,
        ST_TOP_RD,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_SORT_K,
        RD_BELOW_IDX,
        RD_TOP
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_PUSH,
        WR_KEY_AT_IDX,
        WR_DATA_AT_IDX
    } wr_sel_t;

    typedef struct packed {
        logic         accept;
        logic         set_status;
        status_code_t status_code;
        logic         ins_init;
        logic         sort_init;
        logic         sort_load;
        rd_sel_t      rd_sel;
        wr_sel_t      wr_sel;
        logic         idx_dec;
        logic         k_inc;
        logic         fill_inc;
        logic         fill_dec;
        logic         out_load;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    full;
        logic    empty;
        logic    one_or_less;
        logic    idx_zero;
        logic    less;
        logic    k_last;
        logic    out_free;
    } stat_t;

    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 40;

endpackage

`default_nettype wire

### sv/sse_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sse_dp #(
    parameter int DEPTH        = 16,
    parameter int ELEMENT_BITS = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [sse_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  wire sse_pkg::cmd_t                      cmd,
    output sse_pkg::stat_t                          stat,
    output logic                                    m_tvalid,
    output logic [sse_pkg::M_TDATA_BITS-1:0]        m_tdata,
    input  wire logic                               m_tready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [ELEMENT_BITS-1:0]            mem [DEPTH];
    sse_pkg::action_t                   action_reg;
    logic [ELEMENT_BITS-1:0]            key_reg;
    logic [CW-1:0]                      fill_reg;
    logic [CW-1:0]                      idx_reg;
    logic [CW-1:0]                      k_reg;
    sse_pkg::status_code_t              status_reg;
    logic [ELEMENT_BITS-1:0]            rdata_reg;
    logic                               m_tvalid_reg;
    logic [sse_pkg::M_TDATA_BITS-1:0]   m_tdata_reg;

    logic [63:0]                        value_ext;
    logic [ELEMENT_BITS-1:0]            key_in;
    logic [CW-1:0]                      idx_m1;
    logic                               wr_en;
    logic [CW-1:0]                      wr_idx;
    logic [ELEMENT_BITS-1:0]            wr_data;
    logic                               rd_en;
    logic [CW-1:0]                      rd_idx;
    logic                               empty;
    logic [63:0]                        top_wide;
    logic [31:0]                        top32;
    logic [15:0]                        fill_wide;

    // sign-extend the 32-bit value, then cut to element width
    assign value_ext = {{32{s_tdata[33]}}, s_tdata[33:2]};
    assign key_in    = value_ext[ELEMENT_BITS-1:0];
    assign idx_m1    = idx_reg - CW'(1);
    assign empty     = (fill_reg == '0);

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = idx_reg;
        wr_data = key_reg;
        unique case (cmd.wr_sel)
            sse_pkg::WR_NONE: begin
                wr_en = 1'b0;
            end
            sse_pkg::WR_PUSH: begin
                wr_en  = 1'b1;
                wr_idx = fill_reg;
            end
            sse_pkg::WR_KEY_AT_IDX: begin
                wr_en = 1'b1;
            end
            sse_pkg::WR_DATA_AT_IDX: begin
                wr_en   = 1'b1;
                wr_data = rdata_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        rd_en  = 1'b0;
        rd_idx = idx_m1;
        unique case (cmd.rd_sel)
            sse_pkg::RD_NONE: begin
                rd_en = 1'b0;
            end
            sse_pkg::RD_SORT_K: begin
                rd_en  = 1'b1;
                rd_idx = k_reg;
            end
            sse_pkg::RD_BELOW_IDX: begin
                rd_en = 1'b1;
            end
            sse_pkg::RD_TOP: begin
                rd_en  = !empty;
                rd_idx = fill_reg - CW'(1);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.fill_inc) begin
                fill_reg <= fill_reg + CW'(1);
            end else if (cmd.fill_dec) begin
                fill_reg <= fill_reg - CW'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign top_wide  = 64'(rdata_reg);
    assign top32     = empty ? 32'd0 : top_wide[31:0];
    assign fill_wide = 16'(fill_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            action_reg <= sse_pkg::action_t'(s_tdata[1:0]);
            status_reg <= sse_pkg::STS_DONE;
        end else if (cmd.set_status) begin
            status_reg <= cmd.status_code;
        end
        if (cmd.accept) begin
            key_reg <= key_in;
        end else if (cmd.sort_load) begin
            key_reg <= rdata_reg;
        end
        if (cmd.ins_init) begin
            idx_reg <= fill_reg;
        end else if (cmd.sort_load) begin
            idx_reg <= k_reg;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_m1;
        end
        if (cmd.sort_init) begin
            k_reg <= CW'(1);
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + CW'(1);
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {status_reg, fill_wide[4:0], !empty, top32};
        end
    end

    assign stat.action      = action_reg;
    assign stat.full        = (fill_reg == CW'(DEPTH));
    assign stat.empty       = empty;
    assign stat.one_or_less = (fill_reg <= CW'(1));
    assign stat.idx_zero    = (idx_reg == '0);
    assign stat.less        = ($signed(rdata_reg) < $signed(key_reg));
    assign stat.k_last      = ((k_reg + CW'(1)) == fill_reg);
    assign stat.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (wr_idx < CW'(DEPTH)))
        else $error("write beyond stack depth");

    a_rd_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("read and write in the same cycle");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before taken");

endmodule

`default_nettype wire

### sv/sse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sse_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire sse_pkg::stat_t  stat,
    output sse_pkg::cmd_t        cmd
);

    sse_pkg::state_t state_reg;
    sse_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sse_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sse_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sse_pkg::ST_DISPATCH;
                end
            end
            sse_pkg::ST_DISPATCH: begin
                unique case (stat.action)
                    sse_pkg::ACT_INSERT: begin
                        state_next = stat.full ? sse_pkg::ST_TOP_RD : sse_pkg::ST_INS_RD;
                    end
                    sse_pkg::ACT_SORT: begin
                        state_next = stat.one_or_less ? sse_pkg::ST_TOP_RD
                                                      : sse_pkg::ST_SORT_RD;
                    end
                    default: begin
                        state_next = sse_pkg::ST_TOP_RD;
                    end
                endcase
            end
            sse_pkg::ST_SORT_RD: begin
                state_next = sse_pkg::ST_SORT_LD;
            end
            sse_pkg::ST_SORT_LD: begin
                state_next = sse_pkg::ST_INS_RD;
            end
            sse_pkg::ST_INS_RD: begin
                state_next = stat.idx_zero ? sse_pkg::ST_INS_END : sse_pkg::ST_INS_CMP;
            end
            sse_pkg::ST_INS_CMP: begin
                state_next = stat.less ? sse_pkg::ST_INS_END : sse_pkg::ST_INS_RD;
            end
            sse_pkg::ST_INS_END: begin
                if (stat.action == sse_pkg::ACT_SORT && !stat.k_last) begin
                    state_next = sse_pkg::ST_SORT_RD;
                end else begin
                    state_next = sse_pkg::ST_TOP_RD;
                end
            end
            sse_pkg::ST_TOP_RD: begin
                state_next = sse_pkg::ST_RESULT;
            end
            sse_pkg::ST_RESULT: begin
                if (stat.out_free) begin
                    state_next = sse_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            sse_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            sse_pkg::ST_DISPATCH: begin
                unique case (stat.action)
                    sse_pkg::ACT_PUSH: begin
                        if (stat.full) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = sse_pkg::STS_FULL;
                        end else begin
                            cmd.wr_sel   = sse_pkg::WR_PUSH;
                            cmd.fill_inc = 1'b1;
                        end
                    end
                    sse_pkg::ACT_POP: begin
                        if (stat.empty) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = sse_pkg::STS_EMPTY;
                        end else begin
                            cmd.fill_dec = 1'b1;
                        end
                    end
                    sse_pkg::ACT_INSERT: begin
                        if (stat.full) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = sse_pkg::STS_FULL;
                        end else begin
                            cmd.ins_init = 1'b1;
                        end
                    end
                    sse_pkg::ACT_SORT: begin
                        cmd.sort_init = !stat.one_or_less;
                    end
                    default: begin
                        cmd.set_status = 1'b0;
                    end
                endcase
            end
            sse_pkg::ST_SORT_RD: begin
                cmd.rd_sel = sse_pkg::RD_SORT_K;
            end
            sse_pkg::ST_SORT_LD: begin
                cmd.sort_load = 1'b1;
            end
            sse_pkg::ST_INS_RD: begin
                if (stat.idx_zero) begin
                    cmd.wr_sel = sse_pkg::WR_KEY_AT_IDX;
                end else begin
                    cmd.rd_sel = sse_pkg::RD_BELOW_IDX;
                end
            end
            sse_pkg::ST_INS_CMP: begin
                if (stat.less) begin
                    cmd.wr_sel = sse_pkg::WR_KEY_AT_IDX;
                end else begin
                    cmd.wr_sel  = sse_pkg::WR_DATA_AT_IDX;
                    cmd.idx_dec = 1'b1;
                end
            end
            sse_pkg::ST_INS_END: begin
                if (stat.action == sse_pkg::ACT_SORT) begin
                    cmd.k_inc = !stat.k_last;
                end else begin
                    cmd.fill_inc = 1'b1;
                end
            end
            sse_pkg::ST_TOP_RD: begin
                cmd.rd_sel = sse_pkg::RD_TOP;
            end
            sse_pkg::ST_RESULT: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    a_cmp_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sse_pkg::ST_INS_CMP |-> $past(state_reg) == sse_pkg::ST_INS_RD)
        else $error("compare without a preceding read");

    a_load_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sse_pkg::ST_SORT_LD |-> $past(state_reg) == sse_pkg::ST_SORT_RD)
        else $error("sort key load without a preceding read");

endmodule

`default_nettype wire

### sv/sorted_stack_engine.sv
// flow: push, pop and refused requests go via dispatch, top read and result to m_tvalid
// sorted insert: adds a read and compare per entry shifted up and an end step; a compare
// ends the scan when it stops above the bottom. sort: per entry 1..n-1, key read and load,
// then the read and compare scan and an end step, insertion sort
// throughput: one request at a time; next request taken once the result is registered
// reset: synchronous active-low aresetn empties the stack and clears the result valid
`timescale 1ns / 1ps
`default_nettype none

module sorted_stack_engine #(
    parameter int DEPTH        = 16,
    parameter int ELEMENT_BITS = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // action [1:0], value [33:2], zero [39:34]
    input  wire logic [sse_pkg::S_TDATA_BITS-1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // top_value [31:0], top_valid [32], count [37:33], status [39:38]
    output logic [sse_pkg::M_TDATA_BITS-1:0]        m_tdata
);

    sse_pkg::cmd_t  cmd;
    sse_pkg::stat_t stat;

    sse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sse_dp #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tready (m_tready)
    );

endmodule

`default_nettype wire
